// ===== sv/hsl_to_rgb_assert.svh =====
// Assertion macros for the HSL to RGB converter.
// Each macro checks under the block clock and is off while reset is held.
`ifndef HSL_TO_RGB_ASSERT_SVH
`define HSL_TO_RGB_ASSERT_SVH

// Same-cycle implication
`define HSL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define HSL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hsl_pkg.sv =====
package hsl_pkg;

  // Fixed-point format: FRAC_BITS fraction bits, ONE is 1.0
  localparam int FRAC_BITS = 12;
  localparam int ONE       = 1 << FRAC_BITS;
  localparam int HALF      = 1 << (FRAC_BITS - 1);

  // Field widths
  localparam int FW    = FRAC_BITS + 1;   // sat, light and color channels
  localparam int HUE_W = 9;
  localparam int P_W   = 2 * FW;          // L*S product
  localparam int D_W   = FW + 1;          // top/min values with headroom
  localparam int REM_W = 6;               // degrees within a sextant
  localparam int X_W   = D_W + REM_W;     // (v-min)*rem + rounding

  // Hue constants
  localparam int DEG_FULL = 360;
  localparam int DEG_SEXT = 60;
  localparam int RND_SEXT = DEG_SEXT / 2;
  localparam int N_SEXT   = DEG_FULL / DEG_SEXT;

  // Divide by 60 as multiply by ceil(2^24/60), exact for x < 381300
  localparam int RECIP_SH = 24;
  localparam int RECIP    = ((1 << RECIP_SH) + DEG_SEXT - 1) / DEG_SEXT;
  localparam int RECIP_W  = 19;
  localparam int Q_W      = X_W + RECIP_W;

  // Hue sextant codes
  typedef enum logic [2:0] {
    SEXT_RY = 3'd0,   // red to yellow
    SEXT_YG = 3'd1,   // yellow to green
    SEXT_GC = 3'd2,   // green to cyan
    SEXT_CB = 3'd3,   // cyan to blue
    SEXT_BM = 3'd4,   // blue to magenta
    SEXT_MR = 3'd5    // magenta to red
  } sext_t;

  // Stage 1: clamped inputs, L*S product, hue split
  typedef struct packed {
    logic [FW-1:0]    sat;
    logic [FW-1:0]    light;
    logic [P_W-1:0]   prod;
    sext_t            sext;
    logic [REM_W-1:0] rem;
    logic             low_half;
  } s1_t;

  // Stage 2: top and min values, numerator of the mid offset
  typedef struct packed {
    logic [D_W-1:0] vtop;
    logic [D_W-1:0] vmin;
    logic [X_W-1:0] numer;
    sext_t          sext;
    logic           black;
  } s2_t;

  // Stage 3: mid offset after the divide by 60
  typedef struct packed {
    logic [D_W-1:0] vtop;
    logic [D_W-1:0] vmin;
    logic [D_W-1:0] vsf;
    sext_t          sext;
    logic           black;
  } s3_t;

endpackage

// ===== sv/hsl_in_if.sv =====
interface hsl_in_if import hsl_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [HUE_W-1:0] hue;
  logic [FW-1:0]    saturation;
  logic [FW-1:0]    lightness;

  modport source (output valid, output hue, output saturation, output lightness,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input lightness,
                  output ready);
endinterface

// ===== sv/hsl_out_if.sv =====
interface hsl_out_if import hsl_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [FW-1:0] red;
  logic [FW-1:0] green;
  logic [FW-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

// ===== sv/hsl_split.sv =====
module hsl_split import hsl_pkg::*; (
  input  logic             clk,
  input  logic             ld,
  input  logic [HUE_W-1:0] hue,
  input  logic [FW-1:0]    saturation,
  input  logic [FW-1:0]    lightness,
  output s1_t              st_r
);

  logic [FW-1:0]    sat_c, light_c;
  logic [HUE_W-1:0] hue_w, base;
  s1_t              st_nxt;

  // Clamp fractions to 1.0
  assign sat_c   = (saturation > FW'(ONE)) ? FW'(ONE) : saturation;
  assign light_c = (lightness  > FW'(ONE)) ? FW'(ONE) : lightness;

  // Wrap hue into 0..359, then find sextant and offset
  assign hue_w = (hue >= HUE_W'(DEG_FULL)) ? hue - HUE_W'(DEG_FULL) : hue;

  always_comb begin
    st_nxt.sext = SEXT_RY;
    base        = '0;
    for (int k = 1; k < N_SEXT; k++) begin
      if (hue_w >= HUE_W'(k * DEG_SEXT)) begin
        st_nxt.sext = sext_t'(3'(k));
        base        = HUE_W'(k * DEG_SEXT);
      end
    end
    st_nxt.rem      = REM_W'(hue_w - base);
    st_nxt.sat      = sat_c;
    st_nxt.light    = light_c;
    st_nxt.prod     = P_W'(light_c) * P_W'(sat_c);
    st_nxt.low_half = (light_c <= FW'(HALF));
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      st_r <= st_nxt;
    end
  end

endmodule

// ===== sv/hsl_core.sv =====
module hsl_core import hsl_pkg::*; (
  input  logic clk,
  input  logic ld2,
  input  logic ld3,
  input  s1_t  st1,
  output s3_t  st3_r
);

  logic [P_W:0]   rnd_sum;
  logic [D_W-1:0] rnd, lx, sx, diff;
  logic [Q_W-1:0] quot;
  s2_t            st2_r, st2_nxt;
  s3_t            st3_nxt;

  // Stage 2: v = L*(1+S) or L+S-L*S, min = 2L-v, numerator (v-min)*rem+30
  always_comb begin
    rnd_sum       = {1'b0, st1.prod} + (P_W + 1)'(HALF);
    rnd           = D_W'(rnd_sum >> FRAC_BITS);
    lx            = D_W'(st1.light);
    sx            = D_W'(st1.sat);
    st2_nxt.vtop  = st1.low_half ? lx + rnd : lx + sx - rnd;
    st2_nxt.vmin  = (lx << 1) - st2_nxt.vtop;
    diff          = st2_nxt.vtop - st2_nxt.vmin;
    st2_nxt.numer = X_W'(diff) * X_W'(st1.rem) + X_W'(RND_SEXT);
    st2_nxt.sext  = st1.sext;
    st2_nxt.black = (st2_nxt.vtop == '0);
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      st2_r <= st2_nxt;
    end
  end

  // Stage 3: divide by 60 through the reciprocal
  always_comb begin
    quot          = Q_W'(st2_r.numer) * Q_W'(RECIP);
    st3_nxt.vsf   = D_W'(quot >> RECIP_SH);
    st3_nxt.vtop  = st2_r.vtop;
    st3_nxt.vmin  = st2_r.vmin;
    st3_nxt.sext  = st2_r.sext;
    st3_nxt.black = st2_r.black;
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      st3_r <= st3_nxt;
    end
  end

endmodule

// ===== sv/hsl_mix.sv =====
module hsl_mix import hsl_pkg::*; (
  input  logic          clk,
  input  logic          ld,
  input  s3_t           st3,
  output logic [FW-1:0] red_r,
  output logic [FW-1:0] green_r,
  output logic [FW-1:0] blue_r
);

  logic [D_W-1:0] mid1, mid2, r_w, g_w, b_w;
  logic [FW-1:0]  red_nxt, green_nxt, blue_nxt;

  function automatic logic [FW-1:0] sat_one(input logic [D_W-1:0] x);
    return (x > D_W'(ONE)) ? FW'(ONE) : FW'(x);
  endfunction

  assign mid1 = st3.vmin + st3.vsf;
  assign mid2 = st3.vtop - st3.vsf;

  // Route top, mid and min values by sextant, clamp each to 1.0, or zero all when black
  always_comb begin
    case (st3.sext)
      SEXT_RY: begin r_w = st3.vtop; g_w = mid1;     b_w = st3.vmin; end
      SEXT_YG: begin r_w = mid2;     g_w = st3.vtop; b_w = st3.vmin; end
      SEXT_GC: begin r_w = st3.vmin; g_w = st3.vtop; b_w = mid1;     end
      SEXT_CB: begin r_w = st3.vmin; g_w = mid2;     b_w = st3.vtop; end
      SEXT_BM: begin r_w = mid1;     g_w = st3.vmin; b_w = st3.vtop; end
      default: begin r_w = st3.vtop; g_w = st3.vmin; b_w = mid2;     end
    endcase
    if (st3.black) begin
      red_nxt   = '0;
      green_nxt = '0;
      blue_nxt  = '0;
    end else begin
      red_nxt   = sat_one(r_w);
      green_nxt = sat_one(g_w);
      blue_nxt  = sat_one(b_w);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (ld) begin
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

endmodule

// ===== sv/hsl_to_rgb.sv =====
// HSL to RGB color converter, sextant method, 12 fraction bits (4096 = 1.0).
// in_ch: valid/ready request carrying hue (degrees, 360 wraps to 0),
//   saturation and lightness; fractions above 1.0 are clamped.
// out_ch: valid/ready request carrying red, green and blue in 0..4096.
// Pipeline of four register stages: clamp, hue split and L*S multiply;
//   top/min values and the (v-min)*rem multiply; the divide by 60 as a
//   reciprocal multiply; channel routing into the output register.
// An accepted request passes through each stage register in turn before out_ch.valid.
// Throughput: one request per cycle while out_ch.ready stays high.
// A request is taken whenever some stage ahead has room, so bubbles
//   collapse while the receiver stalls; a full pipe holds all four
//   requests in place, and nothing is lost or repeated.
// Reset (rst_n low, synchronous) empties all stages; the block keeps no
//   other state and has no configuration.
`include "hsl_to_rgb_assert.svh"

module hsl_to_rgb import hsl_pkg::*; (
  input logic    clk,
  input logic    rst_n,
  hsl_in_if.sink    in_ch,
  hsl_out_if.source out_ch
);

  localparam int NSTG = 4;

  logic [NSTG-1:0] vld_r, vld_nxt, rdy, ld, prev;
  s1_t             st1;
  s3_t             st3;

  // Per-stage room and load enables
  always_comb begin
    rdy[NSTG-1] = !vld_r[NSTG-1] || out_ch.ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    prev = {vld_r[NSTG-2:0], in_ch.valid};
    ld   = rdy & prev;
    for (int k = 0; k < NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? prev[k] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ch.ready  = rdy[0];
  assign out_ch.valid = vld_r[NSTG-1];

  hsl_split u_split (
    .clk        (clk),
    .ld         (ld[0]),
    .hue        (in_ch.hue),
    .saturation (in_ch.saturation),
    .lightness  (in_ch.lightness),
    .st_r       (st1)
  );

  hsl_core u_core (
    .clk   (clk),
    .ld2   (ld[1]),
    .ld3   (ld[2]),
    .st1   (st1),
    .st3_r (st3)
  );

  hsl_mix u_mix (
    .clk     (clk),
    .ld      (ld[3]),
    .st3     (st3),
    .red_r   (out_ch.red),
    .green_r (out_ch.green),
    .blue_r  (out_ch.blue)
  );

  // Checks
  `HSL_ASSERT_IMP(a_out_range, out_ch.valid,
    (out_ch.red <= FW'(ONE)) && (out_ch.green <= FW'(ONE)) && (out_ch.blue <= FW'(ONE)),
    "color channel above full scale")
  `HSL_ASSERT_NXT(a_take_lands, in_ch.valid && in_ch.ready, vld_r[0],
    "accepted request missing from first stage")
  `HSL_ASSERT_NXT(a_stall_holds, vld_r[1] && !rdy[1], vld_r[1] && $stable(vld_r[2]),
    "stalled stage dropped its request")

endmodule

// ===== tb/hsl_to_rgb_checker.sv =====
`timescale 1ns / 100ps

// Watches both channels, predicts the RGB result of every accepted request
// and compares it with what comes out, in order.
module hsl_to_rgb_checker import hsl_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  hsl_in_if    in_ch,
  hsl_out_if   out_ch,
  output int   n_fail,
  output int   n_pending,
  output int   n_checked
);

  typedef struct {
    logic [FW-1:0] red;
    logic [FW-1:0] green;
    logic [FW-1:0] blue;
  } rgb_t;

  rgb_t rgb_pending_q[$];

  // Limit one channel to 0..1.0
  function automatic logic [FW-1:0] clip_channel(longint x);
    if (x < 0) return '0;
    if (x > ONE) return FW'(ONE);
    return FW'(x);
  endfunction

  // Sextant conversion in fixed point, rounding half up
  function automatic rgb_t hsl_rgb_predict(logic [HUE_W-1:0] hue_in,
                                           logic [FW-1:0] sat_in,
                                           logic [FW-1:0] light_in);
    longint h, s, l, vtop, vlow, span, vsf, up, down;
    sext_t  sext;
    rgb_t   rgb;
    rgb = '{red: '0, green: '0, blue: '0};
    h = hue_in;
    if (h >= DEG_FULL) h -= DEG_FULL;
    s = (sat_in > ONE) ? ONE : sat_in;
    l = (light_in > ONE) ? ONE : light_in;

    // top value depends on which half lightness sits in
    if (2 * l <= ONE)
      vtop = (l * (ONE + s) + HALF) >>> FRAC_BITS;
    else
      vtop = l + s - ((l * s + HALF) >>> FRAC_BITS);
    if (vtop <= 0) return rgb;

    vlow = 2 * l - vtop;
    span = (vtop - vlow) * (h % DEG_SEXT);
    if (span >= 0) vsf = (span + RND_SEXT) / DEG_SEXT;
    else vsf = -((-span + RND_SEXT - 1) / DEG_SEXT);
    up   = vlow + vsf;
    down = vtop - vsf;

    // route top, rising, falling and low values per sextant
    sext = sext_t'(h / DEG_SEXT);
    case (sext)
      SEXT_RY: begin
        rgb.red = clip_channel(vtop); rgb.green = clip_channel(up);
        rgb.blue = clip_channel(vlow);
      end
      SEXT_YG: begin
        rgb.red = clip_channel(down); rgb.green = clip_channel(vtop);
        rgb.blue = clip_channel(vlow);
      end
      SEXT_GC: begin
        rgb.red = clip_channel(vlow); rgb.green = clip_channel(vtop);
        rgb.blue = clip_channel(up);
      end
      SEXT_CB: begin
        rgb.red = clip_channel(vlow); rgb.green = clip_channel(down);
        rgb.blue = clip_channel(vtop);
      end
      SEXT_BM: begin
        rgb.red = clip_channel(up); rgb.green = clip_channel(vlow);
        rgb.blue = clip_channel(vtop);
      end
      default: begin
        rgb.red = clip_channel(vtop); rgb.green = clip_channel(vlow);
        rgb.blue = clip_channel(down);
      end
    endcase
    return rgb;
  endfunction

  initial begin
    n_fail    = 0;
    n_pending = 0;
    n_checked = 0;
  end

  // Queue predictions on input requests, compare on result requests
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        rgb_pending_q.push_back(hsl_rgb_predict(in_ch.hue, in_ch.saturation,
                                                in_ch.lightness));
      if (out_ch.valid && out_ch.ready) begin
        if (rgb_pending_q.size() == 0) begin
          $error("result red=%0d green=%0d blue=%0d with no request outstanding",
                 out_ch.red, out_ch.green, out_ch.blue);
          n_fail++;
        end else begin
          want = rgb_pending_q.pop_front();
          n_checked++;
          if (out_ch.red !== want.red) begin
            $error("red: expected %0d, got %0d", want.red, out_ch.red);
            n_fail++;
          end
          if (out_ch.green !== want.green) begin
            $error("green: expected %0d, got %0d", want.green, out_ch.green);
            n_fail++;
          end
          if (out_ch.blue !== want.blue) begin
            $error("blue: expected %0d, got %0d", want.blue, out_ch.blue);
            n_fail++;
          end
        end
      end
      n_pending = rgb_pending_q.size();
    end
  end

endmodule

// ===== tb/hsl_to_rgb_test.sv =====
`timescale 1ns / 100ps

module hsl_to_rgb_test;
  import hsl_pkg::*;

  localparam int N_RANDOM    = 700;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_WAIT  = 8;

  typedef enum {RX_STEADY, RX_COIN, RX_SPARSE, RX_PERIODIC} rx_mode_t;

  logic clk;
  logic rst_n;
  int   n_fail, n_pending, n_checked;
  int   n_sent, n_directed;
  int   burst_left;
  int   cycle_cnt;

  hsl_in_if  in_ch();
  hsl_out_if out_ch();

  hsl_to_rgb i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  hsl_to_rgb_checker i_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .n_fail    (n_fail),
    .n_pending (n_pending),
    .n_checked (n_checked)
  );

  // Clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Watchdog
  initial cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("hsl_to_rgb test failed");
      $finish;
    end
  end

  // Receiver backpressure: stretches of different stall patterns
  initial begin
    rx_mode_t mode;
    int       left, phase;
    out_ch.ready = 1'b0;
    mode  = RX_STEADY;
    left  = 0;
    phase = 0;
    forever begin
      @(negedge clk);
      if (left == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        left = $urandom_range(20, 120);
      end
      left--;
      phase++;
      case (mode)
        RX_STEADY: out_ch.ready <= 1'b1;
        RX_COIN:   out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= ($urandom_range(0, 7) != 0);
        default:   out_ch.ready <= (phase % 5) >= 2;
      endcase
    end
  end

  // Send one color; called at a falling edge, returns at a falling edge
  task automatic send_color(input logic [HUE_W-1:0] h, input logic [FW-1:0] s,
                            input logic [FW-1:0] l);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) begin
        in_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(negedge clk);
      end
    end
    burst_left--;
    in_ch.valid      <= 1'b1;
    in_ch.hue        <= h;
    in_ch.saturation <= s;
    in_ch.lightness  <= l;
    do @(posedge clk); while (!in_ch.ready);
    n_sent++;
    @(negedge clk);
  endtask

  // Fraction mostly in range, sometimes above 1.0 or at a corner
  function automatic logic [FW-1:0] pick_fraction();
    int roll;
    roll = $urandom_range(0, 9);
    if (roll < 8) return FW'($urandom_range(0, ONE));
    if (roll == 8) return FW'($urandom_range(ONE + 1, (1 << FW) - 1));
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return FW'(ONE);
      2:       return FW'(HALF);
      3:       return FW'(HALF + 1);
      default: return FW'(1);
    endcase
  endfunction

  // Corner colors: sextant edges, hue wrap, gray, black, white, clamping
  logic [HUE_W-1:0] dir_hue[24] = '{0, 60, 120, 180, 240, 300, 359, 360, 361, 511,
                                    30, 90, 150, 210, 270, 330, 0, 45, 105, 165,
                                    225, 59, 119, 285};
  logic [FW-1:0]    dir_sat[24] = '{4096, 4096, 4096, 4096, 4096, 4096, 4096, 4096,
                                    4096, 4096, 0, 4096, 4096, 8191, 2048, 8191, 0,
                                    4096, 1, 4095, 2731, 4096, 4096, 1234};
  logic [FW-1:0]    dir_lit[24] = '{2048, 2048, 2048, 2048, 2048, 2048, 2048, 2048,
                                    2048, 2048, 2048, 0, 4096, 2048, 8191, 8191, 0,
                                    1, 2049, 2047, 4095, 2048, 2048, 3000};

  initial begin
    logic [HUE_W-1:0] h;
    n_sent           = 0;
    n_directed       = 0;
    burst_left       = 0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.hue        = '0;
    in_ch.saturation = '0;
    in_ch.lightness  = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed corners
    foreach (dir_hue[i]) send_color(dir_hue[i], dir_sat[i], dir_lit[i]);
    n_directed = n_sent;

    // random colors, hue sometimes past the wrap
    repeat (N_RANDOM) begin
      if ($urandom_range(0, 9) == 0) h = HUE_W'($urandom_range(DEG_FULL, (1 << HUE_W) - 1));
      else h = HUE_W'($urandom_range(0, DEG_FULL - 1));
      send_color(h, pick_fraction(), pick_fraction());
    end
    in_ch.valid <= 1'b0;

    // drain the pipe
    do @(negedge clk); while (n_pending != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("Sent %0d colors (%0d directed corners, rest random incl. clamped inputs",
             n_sent, n_directed);
    $display("and hues past 360); %0d RGB results compared under random stalls.",
             n_checked);
    if (n_fail == 0)
      $display("hsl_to_rgb test passed");
    else
      $display("hsl_to_rgb test failed");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/hsl_pkg.sv
sv/hsl_in_if.sv
sv/hsl_out_if.sv
sv/hsl_split.sv
sv/hsl_core.sv
sv/hsl_mix.sv
sv/hsl_to_rgb.sv
tb/hsl_to_rgb_checker.sv
tb/hsl_to_rgb_test.sv
